FILE: hw/rtl/dhc_pkg.sv
// ----------------------------------------------------------------------------
// dhc_pkg: shared types and constants of the diverging heatmap color block
// Widths, register codes, the pipeline word of the band and weight divider
// and the eleven-entry brown-white-teal palette.
// ----------------------------------------------------------------------------
package dhc_pkg;

  localparam int DENS_W    = 32;  // unsigned Q16.16 density
  localparam int TOL_W     = 16;
  localparam int WEIGHT_W  = 8;
  localparam int CHAN_W    = 8;
  localparam int BAND_BITS = 3;   // band quotient is 0..4
  localparam int IDX_W     = 4;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REM_W     = DENS_W + BAND_BITS;
  // Band bits, one step that forms the weight numerator, then the weight bits.
  localparam int DIV_STAGES = BAND_BITS + 1 + WEIGHT_W + 1;

  localparam logic [IDX_W-1:0] IDX_FIRST      = 4'd0;
  localparam logic [IDX_W-1:0] IDX_LOWER_BASE = 4'd5;
  localparam logic [IDX_W-1:0] IDX_LAST       = 4'd10;

  typedef enum logic [1:0] {
    REG_MIN  = 2'd0,
    REG_MEAN = 2'd1,
    REG_MAX  = 2'd2,
    REG_TOL  = 2'd3
  } dhc_reg_t;

  typedef struct packed {
    logic               flat;    // fixed palette entry, no blend
    logic [IDX_W-1:0]   base;
    logic [DENS_W-1:0]  span;
    logic [REM_W-1:0]   rem;
    logic [BAND_BITS-1:0] band;
    logic [WEIGHT_W:0]  weight;
  } dhc_div_t;

  function automatic logic [3*CHAN_W-1:0] palette(input logic [IDX_W-1:0] idx);
    logic [3*CHAN_W-1:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h543005;
      4'd1:    rgb = 24'h8c510a;
      4'd2:    rgb = 24'hbf812d;
      4'd3:    rgb = 24'hdfc27d;
      4'd4:    rgb = 24'hf6e8c3;
      4'd5:    rgb = 24'hffffff;
      4'd6:    rgb = 24'hc7eae5;
      4'd7:    rgb = 24'h80cdc1;
      4'd8:    rgb = 24'h35978f;
      4'd9:    rgb = 24'h01665e;
      4'd10:   rgb = 24'h003c30;
      default: rgb = '0;
    endcase
    return rgb;
  endfunction

endpackage

FILE: hw/rtl/dhc_div.sv
// ----------------------------------------------------------------------------
// dhc_div: pipelined band and weight divider
// Restoring division, one quotient bit in each stage but the numerator one:
// band floor(5*off/span), then blend weight floor(2^WEIGHT_W*(span-r)/span).
// ----------------------------------------------------------------------------
module dhc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  dhc_pkg::dhc_div_t in_word,
  output logic             out_valid,
  output dhc_pkg::dhc_div_t out_word
);

  logic [dhc_pkg::DIV_STAGES-1:0] v_r;
  dhc_pkg::dhc_div_t st_r   [dhc_pkg::DIV_STAGES];
  dhc_pkg::dhc_div_t st_nxt [dhc_pkg::DIV_STAGES];

  function automatic dhc_pkg::dhc_div_t step(input dhc_pkg::dhc_div_t s, input int i);
    dhc_pkg::dhc_div_t o;
    logic [dhc_pkg::REM_W-1:0] dvs;
    logic [dhc_pkg::REM_W-1:0] cur;
    o   = s;
    dvs = dhc_pkg::REM_W'(s.span);
    cur = s.rem;
    if (i < dhc_pkg::BAND_BITS) begin
      dvs = dvs << (dhc_pkg::BAND_BITS - 1 - i);
      if (s.rem >= dvs) begin
        o.rem = s.rem - dvs;
        o.band[dhc_pkg::BAND_BITS-1-i] = 1'b1;
      end
    end else if (i == dhc_pkg::BAND_BITS) begin
      // For a blended word the band remainder is below the span, so this never wraps.
      o.rem = dvs - s.rem;
    end else begin
      if (i != dhc_pkg::BAND_BITS + 1) begin
        cur = s.rem << 1;
      end
      o.weight = {s.weight[dhc_pkg::WEIGHT_W-1:0], 1'b0};
      if (cur >= dvs) begin
        o.rem       = cur - dvs;
        o.weight[0] = 1'b1;
      end else begin
        o.rem = cur;
      end
    end
    return o;
  endfunction

  always_comb begin
    for (int i = 0; i < dhc_pkg::DIV_STAGES; i++) begin
      st_nxt[i] = step((i == 0) ? in_word : st_r[(i == 0) ? 0 : i - 1], i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[dhc_pkg::DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = v_r[dhc_pkg::DIV_STAGES-1];
  assign out_word  = st_r[dhc_pkg::DIV_STAGES-1];

endmodule

FILE: hw/rtl/diverging_heatmap_color.sv
// ----------------------------------------------------------------------------
// diverging_heatmap_color: density to RGB on an 11-class diverging palette
// Classifies a Q16.16 density against min, mean and max, divides out the
// band and blend weight in a bit-per-stage pipeline and blends two entries.
//
//   Channel   Direction  Handshake            Word
//   in_       input      in_valid/in_ready    in_density[31:0]
//   out_      output     out_valid/out_ready  out_red, out_green, out_blue
//   cfg_      APB slave  psel/penable/pready  min, mean, max, tolerance
//
// One word enters per cycle while the pipeline advances; there are two classify
// stages, 13 divider stages (all but one resolve a quotient bit) and one blend stage.
// The whole pipeline advances together and freezes while the output word
// is held by out_ready low; bubbles carry a cleared valid bit.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module diverging_heatmap_color (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dhc_pkg::DENS_W-1:0]  in_density,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dhc_pkg::CHAN_W-1:0]  out_red,
  output logic [dhc_pkg::CHAN_W-1:0]  out_green,
  output logic [dhc_pkg::CHAN_W-1:0]  out_blue,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dhc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [dhc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [dhc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int DW = dhc_pkg::DENS_W;

  // Configuration registers.
  logic [DW-1:0]             min_r, mean_r, max_r;
  logic [dhc_pkg::TOL_W-1:0] tol_r;
  dhc_pkg::dhc_reg_t         reg_sel;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_sel    = dhc_pkg::dhc_reg_t'(cfg_paddr[dhc_pkg::ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= DW'(0);
      mean_r <= DW'(65536);
      max_r  <= DW'(131072);
      tol_r  <= dhc_pkg::TOL_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        dhc_pkg::REG_MIN:  min_r  <= cfg_pwdata[DW-1:0];
        dhc_pkg::REG_MEAN: mean_r <= cfg_pwdata[DW-1:0];
        dhc_pkg::REG_MAX:  max_r  <= cfg_pwdata[DW-1:0];
        dhc_pkg::REG_TOL:  tol_r  <= cfg_pwdata[dhc_pkg::TOL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dhc_pkg::REG_MIN:  cfg_prdata = dhc_pkg::DATA_W'(min_r);
      dhc_pkg::REG_MEAN: cfg_prdata = dhc_pkg::DATA_W'(mean_r);
      dhc_pkg::REG_MAX:  cfg_prdata = dhc_pkg::DATA_W'(max_r);
      dhc_pkg::REG_TOL:  cfg_prdata = dhc_pkg::DATA_W'(tol_r);
    endcase
  end

  // Global advance: every stage moves unless the output word is stalled.
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stage 1: differences and compares against the registers.
  logic          s1_v_r;
  logic [DW-1:0] s1_dist_r, s1_span_hi_r, s1_off_hi_r, s1_span_lo_r, s1_off_lo_r;
  logic          s1_ge_mx_r, s1_gt_me_r, s1_gt_mn_r;
  logic [DW:0]   diff_dm;
  logic [DW-1:0] dist_nxt;

  always_comb begin
    diff_dm  = {1'b0, in_density} - {1'b0, min_r};
    dist_nxt = diff_dm[DW] ? (min_r - in_density) : diff_dm[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dist_r    <= dist_nxt;
      s1_ge_mx_r   <= in_density >= max_r;
      s1_gt_me_r   <= in_density > mean_r;
      s1_gt_mn_r   <= !diff_dm[DW] && (diff_dm[DW-1:0] != DW'(0));
      s1_span_hi_r <= max_r - mean_r;
      s1_off_hi_r  <= max_r - in_density;
      s1_span_lo_r <= mean_r - min_r;
      s1_off_lo_r  <= mean_r - in_density;
    end
  end

  // Stage 2: pick the case and form the band numerator 5*off.
  logic              s2_v_r;
  dhc_pkg::dhc_div_t s2_word_r;
  dhc_pkg::dhc_div_t s2_nxt;
  logic [DW-1:0]     off_sel;

  always_comb begin
    s2_nxt        = '0;
    off_sel       = s1_off_hi_r;
    priority if (s1_dist_r <= DW'(tol_r)) begin
      s2_nxt.flat = 1'b1;
      s2_nxt.base = dhc_pkg::IDX_LAST;
    end else if (s1_ge_mx_r) begin
      s2_nxt.flat = 1'b1;
      s2_nxt.base = dhc_pkg::IDX_FIRST;
    end else if (s1_gt_me_r) begin
      s2_nxt.base = dhc_pkg::IDX_FIRST;
      s2_nxt.span = s1_span_hi_r;
    end else if (s1_gt_mn_r) begin
      s2_nxt.base = dhc_pkg::IDX_LOWER_BASE;
      s2_nxt.span = s1_span_lo_r;
      off_sel     = s1_off_lo_r;
    end else begin
      s2_nxt.flat = 1'b1;
      s2_nxt.base = dhc_pkg::IDX_LAST;
    end
    s2_nxt.rem = dhc_pkg::REM_W'(off_sel) + (dhc_pkg::REM_W'(off_sel) << 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_word_r <= s2_nxt;
    end
  end

  // Band and weight division.
  logic              dv_v;
  dhc_pkg::dhc_div_t dv_word;

  dhc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s2_v_r),
    .in_word   (s2_word_r),
    .out_valid (dv_v),
    .out_word  (dv_word)
  );

  // Blend stage, which is also the output register.
  logic [dhc_pkg::IDX_W-1:0]      idx;
  logic [3*dhc_pkg::CHAN_W-1:0]   rgb_hi, rgb_lo, rgb_nxt;
  logic [dhc_pkg::WEIGHT_W:0]     w_hi, w_lo;
  logic [dhc_pkg::CHAN_W+dhc_pkg::WEIGHT_W:0] acc;
  logic [3*dhc_pkg::CHAN_W-1:0]   rgb_r;

  always_comb begin
    // A fixed entry has no span, so its band bits carry nothing useful.
    idx    = dv_word.flat ? dv_word.base
                          : dv_word.base + dhc_pkg::IDX_W'(dv_word.band);
    rgb_hi = dhc_pkg::palette(idx);
    rgb_lo = dhc_pkg::palette(idx + dhc_pkg::IDX_W'(1));
    w_hi   = dv_word.weight;
    w_lo   = (dhc_pkg::WEIGHT_W+1)'(1 << dhc_pkg::WEIGHT_W) - dv_word.weight;
    rgb_nxt = rgb_hi;
    acc     = '0;
    if (!dv_word.flat) begin
      for (int k = 0; k < 3; k++) begin
        acc = (dhc_pkg::CHAN_W+dhc_pkg::WEIGHT_W+1)'(
                rgb_lo[k*dhc_pkg::CHAN_W +: dhc_pkg::CHAN_W] * w_lo)
            + (dhc_pkg::CHAN_W+dhc_pkg::WEIGHT_W+1)'(
                rgb_hi[k*dhc_pkg::CHAN_W +: dhc_pkg::CHAN_W] * w_hi);
        rgb_nxt[k*dhc_pkg::CHAN_W +: dhc_pkg::CHAN_W] =
          acc[dhc_pkg::WEIGHT_W +: dhc_pkg::CHAN_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign out_valid = out_valid_r;
  // Palette words are packed blue in the low byte, red in the high byte.
  assign out_blue  = rgb_r[0 +: dhc_pkg::CHAN_W];
  assign out_green = rgb_r[dhc_pkg::CHAN_W +: dhc_pkg::CHAN_W];
  assign out_red   = rgb_r[2*dhc_pkg::CHAN_W +: dhc_pkg::CHAN_W];

endmodule

FILE: tb/diverging_heatmap_color_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diverging_heatmap_color_chk: scoreboard for the diverging heatmap color block
// Follows the register writes on the APB port and predicts the color of every
// accepted density word. Each accepted result word is then compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module diverging_heatmap_color_chk (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [dhc_pkg::DENS_W-1:0] in_density,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [dhc_pkg::CHAN_W-1:0] out_red,
  input  logic [dhc_pkg::CHAN_W-1:0] out_green,
  input  logic [dhc_pkg::CHAN_W-1:0] out_blue,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [dhc_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [dhc_pkg::DATA_W-1:0] cfg_pwdata,
  output int                         fail_count,
  output int                         pending_words
);

  typedef struct packed {
    logic [dhc_pkg::CHAN_W-1:0] red;
    logic [dhc_pkg::CHAN_W-1:0] green;
    logic [dhc_pkg::CHAN_W-1:0] blue;
  } color_t;

  logic [dhc_pkg::DENS_W-1:0] map_min;
  logic [dhc_pkg::DENS_W-1:0] map_mean;
  logic [dhc_pkg::DENS_W-1:0] map_max;
  logic [dhc_pkg::TOL_W-1:0]  map_tol;
  color_t                     color_q[$];
  int                         errors = 0;

  function automatic logic [23:0] brbg(input logic [dhc_pkg::IDX_W-1:0] idx);
    case (idx)
      4'd0:    return 24'h543005;
      4'd1:    return 24'h8c510a;
      4'd2:    return 24'hbf812d;
      4'd3:    return 24'hdfc27d;
      4'd4:    return 24'hf6e8c3;
      4'd5:    return 24'hffffff;
      4'd6:    return 24'hc7eae5;
      4'd7:    return 24'h80cdc1;
      4'd8:    return 24'h35978f;
      4'd9:    return 24'h01665e;
      default: return 24'h003c30;
    endcase
  endfunction

  function automatic color_t flat_color(input logic [dhc_pkg::IDX_W-1:0] idx);
    logic [23:0] rgb;
    rgb = brbg(idx);
    return '{rgb[23:16], rgb[15:8], rgb[7:0]};
  endfunction

  // Weight w goes to the band's own entry, the rest to the next one down.
  function automatic logic [dhc_pkg::CHAN_W-1:0] blend_channel(input logic [7:0] near_c,
                                                               input logic [7:0] far_c,
                                                               input logic [63:0] w);
    logic [63:0] mix;
    mix = (64'(far_c) * ((64'd1 << dhc_pkg::WEIGHT_W) - w) + 64'(near_c) * w)
          >> dhc_pkg::WEIGHT_W;
    return mix[dhc_pkg::CHAN_W-1:0];
  endfunction

  function automatic color_t predict_color(input logic [dhc_pkg::DENS_W-1:0] density);
    logic [63:0]               d, gap, span, off, band, rem, weight;
    logic [dhc_pkg::IDX_W-1:0] base, idx;
    logic [23:0]               near_rgb, far_rgb;
    color_t                    rgb;
    d   = 64'(density);
    gap = (d >= 64'(map_min)) ? d - 64'(map_min) : 64'(map_min) - d;
    if (gap <= 64'(map_tol)) return flat_color(dhc_pkg::IDX_LAST);
    if (d >= 64'(map_max)) return flat_color(dhc_pkg::IDX_FIRST);
    if (d > 64'(map_mean)) begin
      span = 64'(map_max) - 64'(map_mean);
      off  = 64'(map_max) - d;
      base = dhc_pkg::IDX_FIRST;
    end else if (d > 64'(map_min)) begin
      span = 64'(map_mean) - 64'(map_min);
      off  = 64'(map_mean) - d;
      base = dhc_pkg::IDX_LOWER_BASE;
    end else begin
      return flat_color(dhc_pkg::IDX_LAST);
    end
    band = (off * 5) / span;
    rem  = (off * 5) % span;
    if (band > 4) band = 4;
    idx    = base + dhc_pkg::IDX_W'(band);
    weight = ((span - rem) << dhc_pkg::WEIGHT_W) / span;
    if (weight > (64'd1 << dhc_pkg::WEIGHT_W)) weight = 64'd1 << dhc_pkg::WEIGHT_W;
    near_rgb  = brbg(idx);
    far_rgb   = brbg(idx + 1'b1);
    rgb.red   = blend_channel(near_rgb[23:16], far_rgb[23:16], weight);
    rgb.green = blend_channel(near_rgb[15:8], far_rgb[15:8], weight);
    rgb.blue  = blend_channel(near_rgb[7:0], far_rgb[7:0], weight);
    return rgb;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got_v, want_v);
    errors++;
  endtask

  always @(posedge clk) begin : scoreboard
    color_t got;
    color_t want;
    if (!rst_n) begin
      map_min  = '0;
      map_mean = 32'h0001_0000;
      map_max  = 32'h0002_0000;
      map_tol  = 16'd1;
      color_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_red, out_green, out_blue};
        if (color_q.size() == 0) begin
          report_mismatch("result word with nothing expected", 32'(got), 32'h0);
        end else begin
          want = color_q.pop_front();
          if (got.red != want.red)
            report_mismatch("red", 32'(got.red), 32'(want.red));
          if (got.green != want.green)
            report_mismatch("green", 32'(got.green), 32'(want.green));
          if (got.blue != want.blue)
            report_mismatch("blue", 32'(got.blue), 32'(want.blue));
        end
      end
      if (in_valid && in_ready) color_q.push_back(predict_color(in_density));
      // A register write lands after the prediction of a word taken at the same edge.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (dhc_pkg::dhc_reg_t'(cfg_paddr[dhc_pkg::ADDR_W-1:2]))
          dhc_pkg::REG_MIN:  map_min  = cfg_pwdata[dhc_pkg::DENS_W-1:0];
          dhc_pkg::REG_MEAN: map_mean = cfg_pwdata[dhc_pkg::DENS_W-1:0];
          dhc_pkg::REG_MAX:  map_max  = cfg_pwdata[dhc_pkg::DENS_W-1:0];
          dhc_pkg::REG_TOL:  map_tol  = cfg_pwdata[dhc_pkg::TOL_W-1:0];
          default: ;
        endcase
      end
    end
    pending_words <= color_q.size();
    fail_count    <= errors;
  end

endmodule

FILE: tb/diverging_heatmap_color_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diverging_heatmap_color_tb: stimulus and verdict for the heatmap color block
// Resets the block, sends a short directed set of densities, then runs random
// densities under several register settings, from ordered maps to disordered
// and degenerate ones, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module diverging_heatmap_color_tb;

  localparam int LATENCY     = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 66;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic [dhc_pkg::DENS_W-1:0] in_density  = '0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic [dhc_pkg::CHAN_W-1:0] out_red;
  logic [dhc_pkg::CHAN_W-1:0] out_green;
  logic [dhc_pkg::CHAN_W-1:0] out_blue;
  logic                       cfg_psel    = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite  = 1'b0;
  logic [dhc_pkg::ADDR_W-1:0] cfg_paddr   = '0;
  logic [dhc_pkg::DATA_W-1:0] cfg_pwdata  = '0;
  logic [dhc_pkg::DATA_W-1:0] cfg_prdata;
  logic                       cfg_pready;

  int fail_count;
  int pending_words;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_gen    = 0;

  // Map currently programmed, used to aim the random densities.
  logic [dhc_pkg::DENS_W-1:0] cur_min  = '0;
  logic [dhc_pkg::DENS_W-1:0] cur_mean = 32'h0001_0000;
  logic [dhc_pkg::DENS_W-1:0] cur_max  = 32'h0002_0000;
  logic [dhc_pkg::TOL_W-1:0]  cur_tol  = 16'd1;

  diverging_heatmap_color uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_density  (in_density),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  diverging_heatmap_color_chk chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_density    (in_density),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL diverging_heatmap_color");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_gen moves.
  initial begin : rx_drive
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_density(input logic [dhc_pkg::DENS_W-1:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_density <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and let every outstanding word come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input dhc_pkg::dhc_reg_t idx,
                           input logic [dhc_pkg::DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly densities inside the programmed map or close to its corners,
  // with some full-range noise and bit extremes.
  function automatic logic [dhc_pkg::DENS_W-1:0] pick_density();
    logic [63:0] lo, hi, anchor, swing;
    int          mode;
    lo = 64'(cur_min);
    hi = 64'(cur_min);
    if (64'(cur_mean) < lo) lo = 64'(cur_mean);
    if (64'(cur_max) < lo) lo = 64'(cur_max);
    if (64'(cur_mean) > hi) hi = 64'(cur_mean);
    if (64'(cur_max) > hi) hi = 64'(cur_max);
    mode = $urandom_range(99);
    if (mode < 60)
      return dhc_pkg::DENS_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
    if (mode < 80) begin
      case ($urandom_range(2))
        0:       anchor = 64'(cur_min);
        1:       anchor = 64'(cur_mean);
        default: anchor = 64'(cur_max);
      endcase
      swing = 64'(cur_tol) + 4;
      return dhc_pkg::DENS_W'(anchor + 64'($urandom_range(32'(2 * swing))) - swing);
    end
    if (mode < 92) return $urandom;
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(31);
      default: return ~(32'h1 << $urandom_range(31));
    endcase
  endfunction

  task automatic run_phase(input logic [dhc_pkg::DENS_W-1:0] mn,
                           input logic [dhc_pkg::DENS_W-1:0] me,
                           input logic [dhc_pkg::DENS_W-1:0] mx,
                           input logic [dhc_pkg::TOL_W-1:0] tl,
                           input bit hold_first);
    wait_idle();
    cur_min  = mn;
    cur_mean = me;
    cur_max  = mx;
    cur_tol  = tl;
    write_reg(dhc_pkg::REG_MIN, mn);
    write_reg(dhc_pkg::REG_MEAN, me);
    write_reg(dhc_pkg::REG_MAX, mx);
    write_reg(dhc_pkg::REG_TOL, dhc_pkg::DATA_W'(tl));
    // The sender keeps offering words while the receiver is held off, so the
    // pipeline fills up and the input stalls.
    if (hold_first) hold_gen <= hold_gen + 1;
    repeat (PHASE_WORDS) send_density(pick_density());
  endtask

  initial begin : stimulus
    logic [dhc_pkg::DENS_W-1:0] directed[$];
    logic [dhc_pkg::DENS_W-1:0] ra, rb, rc, swap;
    // Reset map: min 0.0, mean 1.0, max 2.0, tolerance 1. The list covers
    // the minimum and its tolerance, the band edges on both sides of the
    // mean, the mean itself, the maximum and the field extremes.
    directed = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h4000, 32'h8000, 32'h3333,
                 32'hcccc, 32'hcccd, 32'hffff, 32'h1_0000, 32'h1_0001,
                 32'h1_8000, 32'h1_cccc, 32'h1_cccd, 32'h1_ffff, 32'h2_0000,
                 32'h2_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0000,
                 32'hffff_ffff};

    tx_idle_pct = 37;
    rx_idle_pct <= 81;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_density(directed[i]);

    // Ordered map with no tolerance.
    run_phase(32'h0001_0000, 32'h0008_0000, 32'h0010_0000, 16'h0, 1'b0);
    // Widest spans and the largest tolerance.
    run_phase(32'h0, 32'h8000_0000, 32'hffff_ffff, 16'hffff, 1'b0);
    // Spans shorter than the five bands.
    run_phase(32'd100, 32'd103, 32'd107, 16'h0, 1'b0);

    tx_idle_pct = 81;
    rx_idle_pct <= 37;
    // Registers in reverse order.
    run_phase(32'h0005_0000, 32'h0003_0000, 32'h0001_0000, 16'h2, 1'b0);
    // All three points at one density.
    run_phase(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 16'h10, 1'b0);
    ra = $urandom;
    rb = $urandom;
    rc = $urandom;
    if (ra > rb) begin swap = ra; ra = rb; rb = swap; end
    if (rb > rc) begin swap = rb; rb = rc; rc = swap; end
    if (ra > rb) begin swap = ra; ra = rb; rb = swap; end
    run_phase(ra, rb, rc, 16'($urandom), 1'b0);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_phase(32'h0001_0000, 32'h0008_0000, 32'h0010_0000, 16'h40, 1'b1);
    run_phase(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 1'b0);

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS diverging_heatmap_color");
    end else begin
      $display("FAIL diverging_heatmap_color");
    end
    $finish;
  end

endmodule
